// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files, included by tcw_engine.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge out of reset
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcw assertion failed");

// property that must hold on every clock edge, reset included
`define TCW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcw assertion failed");

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/tcw_pkg.sv -----
// shared types and constants of the text console character writer
package tcw_pkg;

  localparam int CURSOR_W = 11;
  localparam int DATA_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int OP_W     = 2;
  localparam int INDEX_W  = 11;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam int TAB_STEP = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_index;
    logic [DATA_W-1:0]   cell_data;
    logic                scrolled;
  } res_t;

endpackage

// ----- rtl/tcw_cell_ram.sv -----
// screen cell memory: one write port, one registered read port
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [tcw_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [tcw_pkg::DATA_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tcw_engine.sv -----
// operation sequencer: cursor, character writes, scroll copy, clear and read
`include "assert_macros.svh"

module tcw_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int ADDR_W = $clog2(COLUMNS * ROWS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tcw_pkg::OP_W-1:0]     in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]  in_cell_index,
  input  logic [tcw_pkg::ATTR_W-1:0]   attr,
  output logic                         res_valid,
  input  logic                         res_ready,
  output tcw_pkg::res_t                res,
  output logic                         mem_we,
  output logic [ADDR_W-1:0]            mem_waddr,
  output logic [tcw_pkg::DATA_W-1:0]   mem_wdata,
  output logic                         mem_re,
  output logic [ADDR_W-1:0]            mem_raddr,
  input  logic [tcw_pkg::DATA_W-1:0]   mem_rdata
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int CT_W = COL_W + 1;
  localparam int RT_W = ROW_W + 1;
  localparam int CMP_W = (ADDR_W > INDEX_W) ? ADDR_W + 1 : INDEX_W + 1;
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] FIRST_SRC = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLUMNS);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]    op_r;
  logic [CHAR_W-1:0]  char_r;
  logic [INDEX_W-1:0] idx_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [ADDR_W-1:0]  ptr_r;
  logic               pend_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic               scroll_r;
  logic [DATA_W-1:0]  data_r;

  logic               accept;
  logic [ADDR_W-1:0]  cur_lin;
  logic [CT_W-1:0]    col_a, col_b;
  logic [RT_W-1:0]    row_a, row_b;
  logic [COL_W-1:0]   col_n;
  logic [ROW_W-1:0]   row_n;
  logic               need_scroll;
  logic               printable;
  logic               idx_ok;
  logic [CMP_W-1:0]   idx_ext;

  assign accept    = in_tvalid && in_tready;
  assign cur_lin   = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign printable = (char_r >= BLANK_CHAR);
  assign idx_ext   = CMP_W'(idx_r);
  assign idx_ok    = (idx_ext < CMP_W'(CELL_COUNT));

  // cursor motion for one character
  always_comb begin
    col_a = {1'b0, col_r};
    row_a = {1'b0, row_r};
    priority if (char_r == CH_BS) begin
      if (col_r != '0) begin
        col_a = {1'b0, col_r} - CT_W'(1);
      end
    end else if (char_r == CH_TAB) begin
      col_a = ({1'b0, col_r} + CT_W'(TAB_STEP)) & ~CT_W'(TAB_STEP - 1);
    end else if (char_r == CH_CR) begin
      col_a = '0;
    end else if (char_r == CH_LF) begin
      col_a = '0;
      row_a = {1'b0, row_r} + RT_W'(1);
    end else if (printable) begin
      col_a = {1'b0, col_r} + CT_W'(1);
    end else begin
      col_a = {1'b0, col_r};
    end

    col_b = col_a;
    row_b = row_a;
    if (col_a >= CT_W'(COLUMNS)) begin
      col_b = '0;
      row_b = row_a + RT_W'(1);
    end

    need_scroll = (row_b >= RT_W'(ROWS));
    col_n = col_b[COL_W-1:0];
    row_n = need_scroll ? ROW_W'(ROWS - 1) : row_b[ROW_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (ptr_r == LAST_CELL) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_WRITE: state_nxt = need_scroll ? ST_SCROLL : ST_DONE;
          OP_CLEAR: state_nxt = ST_CLEAR;
          OP_READ:  state_nxt = idx_ok ? ST_RD_WAIT : ST_DONE;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_SCROLL: begin
        if (ptr_r == LAST_CELL) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (!pend_r && ptr_r == LAST_CELL) state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        if (ptr_r == LAST_CELL) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_nxt = in_tvalid ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_tready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = {attr, BLANK_CHAR};
    mem_re    = 1'b0;
    mem_raddr = ptr_r;
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {ATTR_RESET, BLANK_CHAR};
      end
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: begin
        if (op_r == OP_WRITE && printable) begin
          mem_we    = 1'b1;
          mem_waddr = cur_lin;
          mem_wdata = {attr, char_r};
        end
        if (op_r == OP_READ && idx_ok) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(idx_ext);
        end
      end
      ST_RD_WAIT: ;
      ST_SCROLL: begin
        // read one row ahead, write the cell read last cycle
        mem_re    = 1'b1;
        mem_we    = pend_r;
        mem_waddr = pend_addr_r;
        mem_wdata = mem_rdata;
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (pend_r) begin
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
      end
      ST_CLEAR: mem_we = 1'b1;
      ST_DONE: begin
        res_valid = 1'b1;
        in_tready = res_ready;
      end
      default: ;
    endcase
  end

  assign res.cursor_index = CURSOR_W'(cur_lin);
  assign res.cell_data    = data_r;
  assign res.scrolled     = scroll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
    end
    if (state_r == ST_EXEC) begin
      data_r   <= '0;
      scroll_r <= 1'b0;
      if (op_r == OP_WRITE) begin
        scroll_r <= need_scroll;
      end
    end
    if (state_r == ST_RD_WAIT) begin
      data_r <= mem_rdata;
    end
    if (state_r == ST_SCROLL) begin
      pend_addr_r <= ptr_r - FIRST_SRC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ptr_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_INIT, ST_CLEAR: begin
          ptr_r <= (ptr_r == LAST_CELL) ? '0 : ptr_r + ADDR_W'(1);
        end
        ST_EXEC: begin
          pend_r <= 1'b0;
          if (op_r == OP_WRITE) begin
            col_r <= col_n;
            row_r <= row_n;
            ptr_r <= FIRST_SRC;
          end else if (op_r == OP_CLEAR) begin
            col_r <= '0;
            row_r <= '0;
            ptr_r <= '0;
          end
        end
        ST_SCROLL: begin
          pend_r <= 1'b1;
          ptr_r  <= (ptr_r == LAST_CELL) ? BOTTOM_ROW : ptr_r + ADDR_W'(1);
        end
        ST_FILL: begin
          if (pend_r) begin
            pend_r <= 1'b0;
          end else if (ptr_r != LAST_CELL) begin
            ptr_r <= ptr_r + ADDR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `TCW_ASSERT(a_accept_exec, clk, rst_n, accept |=> state_r == ST_EXEC)
  `TCW_ASSERT(a_no_pend_idle, clk, rst_n, (state_r == ST_IDLE || state_r == ST_DONE) |-> !pend_r)
  `TCW_ASSERT(a_cursor_range, clk, rst_n, (RT_W'(row_r) < RT_W'(ROWS)) && (CT_W'(col_r) < CT_W'(COLUMNS)))
  `TCW_ASSERT(a_waddr_range, clk, rst_n, mem_we |-> ({1'b0, mem_waddr} < (ADDR_W + 1)'(CELL_COUNT)))
  `TCW_ASSERT(a_no_write_on_read, clk, rst_n, (state_r == ST_RD_WAIT || state_r == ST_DONE) |-> !mem_we)

endmodule

// ----- rtl/text_console_char_writer_core.sv -----
// top level of the text console character writer
//
// Keeps a ROWS x COLUMNS screen of 16-bit cells (attribute high byte, character
// low byte) in one synchronous RAM and a cursor in registers. Each request gives
// one result in out_tdata. States from one accepted request to the next: a
// character write or control code passes through execute and done (printable
// characters are written on the RAM write port in execute); an in-range cell
// read adds a wait state for the registered RAM read; op 3 passes through execute
// and done; a clear screen writes one cell per cycle; a write that scrolls copies
// the rows up, reading one cell and writing one cell per cycle through the two
// RAM ports, then blanks the bottom row. After reset the block runs a clearing
// pass that writes white-on-black blanks, with in_tready low; cfg writes are
// taken during it. The next request is accepted in the cycle a result is handed
// to the output register, so a result waiting on out_tready does not stop the
// next request from entering.
module text_console_char_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // op[1:0], char_code[9:2], cell_index[20:10], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_index[10:0], cell_data[26:11], scrolled[27], zero
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata   // attribute
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  logic [ATTR_W-1:0] attr_r;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  res_t              out_r;
  logic              out_valid_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_wen) begin
      attr_r <= cfg_wdata;
    end
  end

  tcw_engine #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_op        (in_tdata[1:0]),
    .in_char_code (in_tdata[9:2]),
    .in_cell_index(in_tdata[20:10]),
    .attr         (attr_r),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  tcw_cell_ram #(
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r.scrolled, out_r.cell_data, out_r.cursor_index};

endmodule

// ----- dv/text_console_char_writer_core_checker.sv -----
// watches the console request and result streams, predicts every result and compares it
module text_console_char_writer_core_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // op[1:0], char_code[9:2], cell_index[20:10], zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // cursor_index[10:0], cell_data[26:11], scrolled[27], zero
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,  // attribute
  output int          error_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [DATA_W-1:0] console_cells [CELLS];
  logic [ATTR_W-1:0] colour_attr;
  int                cur_col;
  int                cur_row;
  res_t              console_results_due[$];
  res_t              got_result;
  res_t              want_result;

  task automatic blank_cells(input int first, input int count);
    for (int i = first; i < first + count && i < CELLS; i++) begin
      console_cells[i] = {colour_attr, BLANK_CHAR};
    end
  endtask

  task automatic console_step(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx, output res_t r);
    r = '0;
    case (op)
      OP_WRITE: begin
        if (ch == CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (ch == CH_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (ch >= BLANK_CHAR) begin
          console_cells[cur_row * COLUMNS + cur_col] = {colour_attr, ch};
          cur_col++;
        end
        // wrap and scroll run for ignored control codes as well
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            console_cells[i] = console_cells[i + COLUMNS];
          end
          blank_cells((ROWS - 1) * COLUMNS, COLUMNS);
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      OP_CLEAR: begin
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        if (idx < CELLS) r.cell_data = console_cells[idx];
      end
      default: ;
    endcase
    r.cursor_index = CURSOR_W'(cur_row * COLUMNS + cur_col);
  endtask

  initial begin
    error_count = 0;
    results_due = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      colour_attr = ATTR_RESET;
      blank_cells(0, CELLS);
      cur_col = 0;
      cur_row = 0;
      console_results_due.delete();
    end else begin
      if (cfg_wen) colour_attr = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got_result.cursor_index = out_tdata[10:0];
        got_result.cell_data    = out_tdata[26:11];
        got_result.scrolled     = out_tdata[27];
        if (console_results_due.size() == 0) begin
          $display("%0t result with no request waiting: expected none, actual %h",
                   $time, out_tdata);
          error_count++;
        end else begin
          want_result = console_results_due.pop_front();
          if (got_result.cursor_index !== want_result.cursor_index) begin
            $display("%0t cursor_index expected %0d actual %0d", $time,
                     want_result.cursor_index, got_result.cursor_index);
            error_count++;
          end
          if (got_result.cell_data !== want_result.cell_data) begin
            $display("%0t cell_data expected %h actual %h", $time,
                     want_result.cell_data, got_result.cell_data);
            error_count++;
          end
          if (got_result.scrolled !== want_result.scrolled) begin
            $display("%0t scrolled expected %0d actual %0d", $time,
                     want_result.scrolled, got_result.scrolled);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        console_step(in_tdata[1:0], in_tdata[9:2], in_tdata[20:10], want_result);
        console_results_due.push_back(want_result);
      end
    end
    results_due = console_results_due.size();
  end

endmodule

// ----- dv/text_console_char_writer_core_tb.sv -----
// stimulus and verdict for the text console character writer core
module text_console_char_writer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int PHASE_ITEMS = 246;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 4 * (1300 * (2 * CELLS + 40) + CELLS + LONG_HOLD + 1000);

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_wen;
  logic [7:0]  cfg_wdata;
  int          error_count;
  int          results_due;
  int          cycle_count;
  bit          tx_fast;
  bit          rx_fast;
  bit          rx_hold;

  text_console_char_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  text_console_char_writer_core_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .error_count(error_count),
    .results_due(results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("text_console_char_writer_core: mismatch");
    $finish;
  end

  // result side: random stall per result, one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        stall = LONG_HOLD;
        rx_hold = 1'b0;
      end else begin
        stall = rx_fast ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [INDEX_W-1:0] idx);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, idx, ch, op};
    @(posedge clk);
    while (!(in_tvalid && in_tready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic draw_request(output logic [OP_W-1:0] op, output logic [CHAR_W-1:0] ch,
                              output logic [INDEX_W-1:0] idx);
    int r;
    r   = $urandom_range(0, 99);
    ch  = CHAR_W'($urandom_range(0, 255));
    idx = INDEX_W'($urandom_range(0, 2047));
    if (r < 78) op = OP_WRITE;
    else if (r < 94) op = OP_READ;
    else if (r < 97) op = OP_CLEAR;
    else op = OP_NONE;
    if (op == OP_WRITE) begin
      r = $urandom_range(0, 99);
      if (r < 55) ch = CHAR_W'($urandom_range(BLANK_CHAR, 255));
      else if (r < 67) ch = CH_LF;
      else if (r < 72) ch = CH_CR;
      else if (r < 80) ch = CH_BS;
      else if (r < 88) ch = CH_TAB;
      else ch = CHAR_W'($urandom_range(0, BLANK_CHAR - 1));
    end else if (op == OP_READ) begin
      r = $urandom_range(0, 99);
      // bias reads towards the rows that take writes and scrolls
      if (r < 45) idx = INDEX_W'($urandom_range(0, CELLS - 1));
      else if (r < 75) idx = INDEX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
      else if (r < 90) idx = INDEX_W'($urandom_range(0, 2 * COLUMNS - 1));
      else idx = INDEX_W'($urandom_range(CELLS, 2047));
    end
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    wait (results_due == 0);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic run_random_phase(input int count, input bit with_hold);
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
        if (with_hold && k == 0) begin
          // sender keeps offering while the receiver sits back
          tx_fast = 1'b1;
          rx_fast = 1'b0;
          rx_hold = 1'b1;
        end
      end
      draw_request(op, ch, idx);
      send_request(op, ch, idx);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    tx_fast   = 1'b0;
    rx_fast   = 1'b0;
    rx_hold   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset attribute
    send_request(OP_READ, 8'h00, 11'd0);
    send_request(OP_READ, 8'hFF, 11'd1999);
    send_request(OP_READ, 8'h00, 11'd2047);
    send_request(OP_READ, 8'h00, 11'd2000);
    send_request(OP_WRITE, CH_BS, 11'd0);      // backspace at the margin
    send_request(OP_WRITE, 8'h00, 11'd0);      // ignored control code
    send_request(OP_WRITE, 8'h1F, 11'h7FF);
    send_request(OP_WRITE, BLANK_CHAR, 11'd0);
    send_request(OP_WRITE, 8'hFF, 11'd0);
    send_request(OP_WRITE, 8'h41, 11'd0);
    send_request(OP_WRITE, CH_TAB, 11'd0);
    send_request(OP_WRITE, CH_TAB, 11'd0);
    send_request(OP_WRITE, 8'h7E, 11'd0);
    send_request(OP_WRITE, CH_BS, 11'd0);
    send_request(OP_WRITE, CH_CR, 11'd0);
    send_request(OP_WRITE, CH_LF, 11'd0);
    send_request(OP_WRITE, 8'h5A, 11'd0);
    send_request(OP_READ, 8'h00, 11'd1);
    send_request(OP_READ, 8'h00, 11'd80);
    send_request(OP_NONE, 8'hFF, 11'h7FF);
    send_request(OP_CLEAR, 8'hFF, 11'h7FF);
    send_request(OP_READ, 8'h00, 11'd3);
    in_tvalid <= 1'b0;

    write_attribute(8'h00);
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_attribute(8'hFF);
    run_random_phase(PHASE_ITEMS, 1'b1);
    write_attribute(ATTR_W'($urandom_range(0, 255)));
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_attribute(8'h5A);
    run_random_phase(PHASE_ITEMS, 1'b0);
    write_attribute(ATTR_W'($urandom_range(0, 255)));
    run_random_phase(PHASE_ITEMS, 1'b0);

    wait (results_due == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("text_console_char_writer_core: match");
    end else begin
      $display("text_console_char_writer_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_engine.sv
rtl/text_console_char_writer_core.sv
dv/text_console_char_writer_core_checker.sv
dv/text_console_char_writer_core_tb.sv
